FILE: hw/rtl/slcc_pkg.sv
// shared types and constants for the source line comment classifier
// no dependencies; imported by every slcc module and the top level
package slcc_pkg;

  // counter widths inside the block
  localparam int LINE_COUNT_BITS = 24;
  localparam int CHAR_COUNT_BITS = 32;

  // result field widths on the ports
  localparam int LINE_OUT_BITS = 24;
  localparam int CHAR_OUT_BITS = 32;

  // item opcodes; the fourth code means nothing and is ignored
  typedef enum logic [1:0] {
    OP_CHAR = 2'd0,
    OP_EOL  = 2'd1,
    OP_EOF  = 2'd2
  } op_t;

  // comment scanner modes
  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_SLASH  = 3'd1,
    MODE_LINE   = 3'd2,
    MODE_BLOCK  = 3'd3,
    MODE_STAR   = 3'd4
  } mode_t;

  // result kinds
  localparam logic KIND_LINE = 1'b0;
  localparam logic KIND_FILE = 1'b1;

  // line classes
  localparam logic [1:0] CLASS_BLANK   = 2'd0;
  localparam logic [1:0] CLASS_CODE    = 2'd1;
  localparam logic [1:0] CLASS_COMMENT = 2'd2;
  localparam logic [1:0] CLASS_MIXED   = 2'd3;

  // comment delimiter bytes
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;

  // events from the scanner to the counters for one item
  typedef struct packed {
    logic char_seen;
    logic line_done;
    logic line_blank;
    logic line_code;
    logic line_comment;
    logic file_end;
  } scan_evt_t;

  // file counters
  typedef struct packed {
    logic [LINE_COUNT_BITS-1:0] lines;
    logic [LINE_COUNT_BITS-1:0] code;
    logic [LINE_COUNT_BITS-1:0] comment;
    logic [LINE_COUNT_BITS-1:0] blank;
    logic [CHAR_COUNT_BITS-1:0] chars;
  } counts_t;

  // whitespace test: 0x09..0x0d and space
  function automatic logic is_space(input logic [7:0] c);
    return ((c >= 8'h09) && (c <= 8'h0D)) || (c == 8'h20);
  endfunction

endpackage

FILE: hw/rtl/slcc_scanner.sv
// comment state scanner: scan mode and per-line flags
// depends on slcc_pkg; emits one scan_evt_t per stepped item
module slcc_scanner
  import slcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [1:0] opcode,
  input  logic [7:0] char_byte,
  output scan_evt_t  evt
);

  mode_t mode, mode_next;
  logic  seen_code, seen_code_next;
  logic  seen_comment, seen_comment_next;
  logic  nonblank, nonblank_next;
  logic  line_open, line_open_next;

  logic  ws;
  logic  fin_code;
  mode_t fin_mode;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_NORMAL;
      seen_code    <= 1'b0;
      seen_comment <= 1'b0;
      nonblank     <= 1'b0;
      line_open    <= 1'b0;
    end else begin
      mode         <= mode_next;
      seen_code    <= seen_code_next;
      seen_comment <= seen_comment_next;
      nonblank     <= nonblank_next;
      line_open    <= line_open_next;
    end
  end

  // line close: a pending slash counts as code, a pending star drops
  always_comb begin
    fin_code = seen_code || (mode == MODE_SLASH);
    fin_mode = ((mode == MODE_STAR) || (mode == MODE_BLOCK)) ? MODE_BLOCK : MODE_NORMAL;
  end

  // next state and events
  always_comb begin
    ws                = is_space(char_byte);
    mode_next         = mode;
    seen_code_next    = seen_code;
    seen_comment_next = seen_comment;
    nonblank_next     = nonblank;
    line_open_next    = line_open;
    evt               = '0;
    evt.line_blank    = !nonblank;
    evt.line_code     = fin_code;
    evt.line_comment  = seen_comment;

    if (step) begin
      unique case (opcode)
        OP_CHAR: begin
          evt.char_seen  = 1'b1;
          line_open_next = 1'b1;
          if (!ws) begin
            nonblank_next = 1'b1;
          end
          unique case (mode)
            MODE_SLASH: begin
              if (char_byte == CHAR_SLASH) begin
                seen_comment_next = 1'b1;
                mode_next         = MODE_LINE;
              end else if (char_byte == CHAR_STAR) begin
                seen_comment_next = 1'b1;
                mode_next         = MODE_BLOCK;
              end else begin
                seen_code_next = 1'b1;
                mode_next      = MODE_NORMAL;
              end
            end
            MODE_LINE: begin
              mode_next = MODE_LINE;
            end
            MODE_BLOCK: begin
              seen_comment_next = 1'b1;
              if (char_byte == CHAR_STAR) begin
                mode_next = MODE_STAR;
              end
            end
            MODE_STAR: begin
              seen_comment_next = 1'b1;
              if (char_byte == CHAR_SLASH) begin
                mode_next = MODE_NORMAL;
              end else if (char_byte != CHAR_STAR) begin
                mode_next = MODE_BLOCK;
              end
            end
            default: begin
              if (char_byte == CHAR_SLASH) begin
                mode_next = MODE_SLASH;
              end else if (!ws) begin
                seen_code_next = 1'b1;
              end
            end
          endcase
        end
        OP_EOL: begin
          evt.line_done     = 1'b1;
          mode_next         = fin_mode;
          seen_code_next    = 1'b0;
          seen_comment_next = 1'b0;
          nonblank_next     = 1'b0;
          line_open_next    = 1'b0;
        end
        OP_EOF: begin
          evt.line_done     = line_open;
          evt.file_end      = 1'b1;
          mode_next         = MODE_NORMAL;
          seen_code_next    = 1'b0;
          seen_comment_next = 1'b0;
          nonblank_next     = 1'b0;
          line_open_next    = 1'b0;
        end
        default: begin
          mode_next = mode;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/slcc_counters.sv
// saturating file counters for lines, code, comment, blank and characters
// depends on slcc_pkg; driven by scan_evt_t from slcc_scanner
module slcc_counters
  import slcc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  scan_evt_t evt,
  output counts_t   upd
);

  counts_t cnt, cnt_next;

  function automatic logic [LINE_COUNT_BITS-1:0] sat_line(
    input logic [LINE_COUNT_BITS-1:0] v, input logic en);
    if (en && (v != '1)) begin
      return v + LINE_COUNT_BITS'(1);
    end
    return v;
  endfunction

  // counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // counts after this item, before any end-of-file clear
  always_comb begin
    upd.lines   = sat_line(cnt.lines, evt.line_done);
    upd.blank   = sat_line(cnt.blank, evt.line_done && evt.line_blank);
    upd.code    = sat_line(cnt.code, evt.line_done && !evt.line_blank && evt.line_code);
    upd.comment = sat_line(cnt.comment,
                           evt.line_done && !evt.line_blank && evt.line_comment);
    if (evt.char_seen && (cnt.chars != '1)) begin
      upd.chars = cnt.chars + CHAR_COUNT_BITS'(1);
    end else begin
      upd.chars = cnt.chars;
    end
  end

  // end of file clears after the summary is taken
  always_comb begin
    cnt_next = cnt;
    if (step) begin
      cnt_next = evt.file_end ? '0 : upd;
    end
  end

endmodule

FILE: hw/rtl/source_line_comment_classifier.sv
// top level of the source line comment classifier
// depends on slcc_pkg, slcc_scanner and slcc_counters
//
//  channel  handshake                   payload
//  item     item_valid / item_ready     opcode, char_byte
//  result   result_valid / result_ready result_kind, line_class, file_*_total
//
// one item per cycle sustained unless a line or file end waits on the result slot;
// input register, then scanner and counter update into the result register
// end of line and end of file give one result each; bytes and the unused code none
// a stalled result holds only items that give a result; bytes keep flowing
// rst is synchronous and clears scan state, line flags and all counters
module source_line_comment_classifier
  import slcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  char_byte,
  output logic        result_valid,
  input  logic        result_ready,
  output logic        result_kind,
  output logic [1:0]  line_class,
  output logic [23:0] file_line_total,
  output logic [23:0] file_code_total,
  output logic [23:0] file_comment_total,
  output logic [23:0] file_blank_total,
  output logic [31:0] file_char_total
);

  logic       s1_valid;
  logic [1:0] s1_opcode;
  logic [7:0] s1_char;
  logic       s1_emits;
  logic       s1_adv;
  logic       slot_free;

  scan_evt_t  evt;
  counts_t    upd;

  // pipeline control
  always_comb begin
    s1_emits   = (s1_opcode == OP_EOL) || (s1_opcode == OP_EOF);
    slot_free  = !result_valid || result_ready;
    s1_adv     = s1_valid && (!s1_emits || slot_free);
    item_ready = !s1_valid || s1_adv;
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      s1_opcode <= opcode;
      s1_char   <= char_byte;
    end
  end

  slcc_scanner u_scanner (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_adv),
    .opcode    (s1_opcode),
    .char_byte (s1_char),
    .evt       (evt)
  );

  slcc_counters u_counters (
    .clk  (clk),
    .rst  (rst),
    .step (s1_adv),
    .evt  (evt),
    .upd  (upd)
  );

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv && s1_emits) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (s1_adv && s1_emits) begin
      result_kind        <= evt.file_end ? KIND_FILE : KIND_LINE;
      if (evt.file_end || evt.line_blank) begin
        line_class <= CLASS_BLANK;
      end else begin
        line_class <= {evt.line_comment, evt.line_code};
      end
      file_line_total    <= LINE_OUT_BITS'(upd.lines);
      file_code_total    <= LINE_OUT_BITS'(upd.code);
      file_comment_total <= LINE_OUT_BITS'(upd.comment);
      file_blank_total   <= LINE_OUT_BITS'(upd.blank);
      file_char_total    <= CHAR_OUT_BITS'(upd.chars);
    end
  end

`ifndef SYNTH
  a_summary_class: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_kind == KIND_FILE) |-> line_class == CLASS_BLANK)
    else $error("summary carries a line class");

  a_blank_le_lines: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> file_blank_total <= file_line_total)
    else $error("blank total above line total");

  a_code_le_lines: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (file_code_total <= file_line_total)
                     && (file_comment_total <= file_line_total))
    else $error("code or comment total above line total");

  a_byte_flows: assert property (@(posedge clk) disable iff (rst)
    s1_valid && (s1_opcode == OP_CHAR) |-> item_ready)
    else $error("byte item blocked by result stage");

  a_held_item: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_opcode))
    else $error("stalled item lost from input register");
`endif

endmodule

FILE: sim/tb_source_line_comment_classifier.sv
// testbench for source_line_comment_classifier: directed rows, then random source files
// depends on slcc_pkg and the classifier rtl; self-checking against an in-bench predictor
`timescale 1ns / 1ps

module tb_source_line_comment_classifier;
  import slcc_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int DIR_ROWS = 25;
  localparam int RANDOM_ITEMS = 1800;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 16;

  // one result as seen on the result channel
  typedef struct packed {
    logic        kind;
    logic [1:0]  cls;
    logic [23:0] lines;
    logic [23:0] code;
    logic [23:0] comment;
    logic [23:0] blank;
    logic [31:0] chars;
  } line_tally_t;

  // directed stimulus row; want is used only when typed is set
  typedef struct {
    logic [1:0]  op;
    logic [7:0]  ch;
    bit          typed;
    line_tally_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  logic [1:0]  opcode = OP_CHAR;
  logic [7:0]  char_byte = 8'h00;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic        result_kind;
  logic [1:0]  line_class;
  logic [23:0] file_line_total;
  logic [23:0] file_code_total;
  logic [23:0] file_comment_total;
  logic [23:0] file_blank_total;
  logic [31:0] file_char_total;

  source_line_comment_classifier uut (
    .clk                (clk),
    .rst                (rst),
    .item_valid         (item_valid),
    .item_ready         (item_ready),
    .opcode             (opcode),
    .char_byte          (char_byte),
    .result_valid       (result_valid),
    .result_ready       (result_ready),
    .result_kind        (result_kind),
    .line_class         (line_class),
    .file_line_total    (file_line_total),
    .file_code_total    (file_code_total),
    .file_comment_total (file_comment_total),
    .file_blank_total   (file_blank_total),
    .file_char_total    (file_char_total)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  mode_t       scan_st = MODE_NORMAL;
  bit          ln_code, ln_comment, ln_nonblank, ln_open;
  logic [23:0] n_lines = '0;
  logic [23:0] n_code = '0;
  logic [23:0] n_comment = '0;
  logic [23:0] n_blank = '0;
  logic [31:0] n_chars = '0;

  line_tally_t expected_tallies [$];
  dir_row_t    dir_rows [DIR_ROWS];

  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int files_seen = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_pct = 0;
  int stall_phase_left = 0;

  function automatic line_tally_t tally_now(input logic kind, input logic [1:0] cls);
    line_tally_t t;
    t = '{kind, cls, n_lines, n_code, n_comment, n_blank, n_chars};
    return t;
  endfunction

  // close the current line: resolve pending marks, classify, bump counters
  task automatic close_line(output logic [1:0] cls);
    if (scan_st == MODE_SLASH) ln_code = 1'b1;
    if (scan_st == MODE_STAR) scan_st = MODE_BLOCK;
    else if (scan_st != MODE_BLOCK) scan_st = MODE_NORMAL;
    if (~&n_lines) n_lines++;
    if (!ln_nonblank) begin
      cls = CLASS_BLANK;
      if (~&n_blank) n_blank++;
    end else begin
      cls = ln_code ? (ln_comment ? CLASS_MIXED : CLASS_CODE)
                    : (ln_comment ? CLASS_COMMENT : CLASS_BLANK);
      if (ln_code && ~&n_code) n_code++;
      if (ln_comment && ~&n_comment) n_comment++;
    end
    ln_code = 1'b0;
    ln_comment = 1'b0;
    ln_nonblank = 1'b0;
    ln_open = 1'b0;
  endtask

  // advance the predictor by one item and give the result it causes, if any
  task automatic classify_item(input logic [1:0] op, input logic [7:0] ch,
                               output bit emits, output line_tally_t t);
    logic [1:0] cls;
    bit ws;
    emits = 1'b0;
    t = '0;
    case (op)
      OP_CHAR: begin
        ws = ((ch >= 8'h09) && (ch <= 8'h0D)) || (ch == 8'h20);
        ln_open = 1'b1;
        if (!ws) ln_nonblank = 1'b1;
        if (~&n_chars) n_chars++;
        case (scan_st)
          MODE_SLASH: begin
            if (ch == CHAR_SLASH) begin
              ln_comment = 1'b1;
              scan_st = MODE_LINE;
            end else if (ch == CHAR_STAR) begin
              ln_comment = 1'b1;
              scan_st = MODE_BLOCK;
            end else begin
              ln_code = 1'b1;
              scan_st = MODE_NORMAL;
            end
          end
          MODE_LINE: ;
          MODE_BLOCK: begin
            ln_comment = 1'b1;
            if (ch == CHAR_STAR) scan_st = MODE_STAR;
          end
          MODE_STAR: begin
            ln_comment = 1'b1;
            if (ch == CHAR_SLASH) scan_st = MODE_NORMAL;
            else if (ch != CHAR_STAR) scan_st = MODE_BLOCK;
          end
          default: begin
            if (ch == CHAR_SLASH) scan_st = MODE_SLASH;
            else if (!ws) ln_code = 1'b1;
          end
        endcase
      end
      OP_EOL: begin
        close_line(cls);
        emits = 1'b1;
        t = tally_now(KIND_LINE, cls);
      end
      OP_EOF: begin
        if (ln_open) close_line(cls);
        emits = 1'b1;
        t = tally_now(KIND_FILE, CLASS_BLANK);
        scan_st = MODE_NORMAL;
        {ln_code, ln_comment, ln_nonblank, ln_open} = '0;
        {n_lines, n_code, n_comment, n_blank, n_chars} = '0;
      end
      default: ;
    endcase
  endtask

  // drive one item in the current burst, wait for its transfer, then predict
  task automatic send_item(input logic [1:0] op, input logic [7:0] ch,
                           input bit typed = 1'b0, input line_tally_t want = '0);
    bit emits;
    line_tally_t t;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      item_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 200)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    item_valid <= 1'b1;
    opcode <= op;
    char_byte <= ch;
    do @(posedge clk); while (!item_ready);
    classify_item(op, ch, emits, t);
    if (emits) expected_tallies.push_back(typed ? want : t);
    items_sent++;
  endtask

  // biased toward comment marks and whitespace, with some arbitrary bytes
  function automatic logic [7:0] pick_char();
    int r;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 22) c = CHAR_SLASH;
    else if (r < 40) c = CHAR_STAR;
    else if (r < 55) c = 8'h20;
    else if (r < 61) c = 8'($urandom_range(9, 13));
    else if (r < 88) c = 8'($urandom_range(8'h61, 8'h7A));
    else c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // receiver stall pattern: phases with their own stall rate
  always @(negedge clk) begin
    if (stall_phase_left == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 60;
        default: stall_pct = 90;
      endcase
      stall_phase_left = $urandom_range(20, 200);
    end
    stall_phase_left--;
    result_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t mismatch %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // result checking against the oldest expectation
  always @(posedge clk) begin
    line_tally_t want;
    if (!rst && result_valid && result_ready) begin
      results_seen++;
      if (result_kind == KIND_FILE) files_seen++;
      if (expected_tallies.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result expected none actual kind %0h class %0h",
                 $time, result_kind, line_class);
      end else begin
        want = expected_tallies.pop_front();
        check_field("result_kind", want.kind, result_kind);
        check_field("line_class", want.cls, line_class);
        check_field("file_line_total", want.lines, file_line_total);
        check_field("file_code_total", want.code, file_code_total);
        check_field("file_comment_total", want.comment, file_comment_total);
        check_field("file_blank_total", want.blank, file_blank_total);
        check_field("file_char_total", want.chars, file_char_total);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t watchdog expired with %0d results outstanding",
               $time, expected_tallies.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int nlines, len;

    // directed rows: empty line after reset, byte extremes, each comment form,
    // blank inside block, lone slash, marks not joining across a line end,
    // unterminated last line at end of file, and end of file on a fresh file
    dir_rows = '{
      '{OP_EOL,    8'h00, 1'b1, '{KIND_LINE, CLASS_BLANK, 24'd1, 24'd0, 24'd0, 24'd1, 32'd0}},
      '{OP_UNUSED, 8'hFF, 1'b0, '0},
      '{OP_CHAR,   8'h00, 1'b0, '0},
      '{OP_CHAR,   8'hFF, 1'b0, '0},
      '{OP_EOL,    8'hFF, 1'b0, '0},
      '{OP_CHAR,   CHAR_SLASH, 1'b0, '0},
      '{OP_CHAR,   CHAR_SLASH, 1'b0, '0},
      '{OP_CHAR,   8'h78, 1'b0, '0},
      '{OP_EOL,    8'h00, 1'b0, '0},
      '{OP_CHAR,   8'h61, 1'b0, '0},
      '{OP_CHAR,   CHAR_SLASH, 1'b0, '0},
      '{OP_CHAR,   CHAR_STAR, 1'b0, '0},
      '{OP_EOL,    8'h00, 1'b0, '0},
      '{OP_CHAR,   8'h20, 1'b0, '0},
      '{OP_EOL,    8'h00, 1'b0, '0},
      '{OP_CHAR,   CHAR_STAR, 1'b0, '0},
      '{OP_CHAR,   CHAR_SLASH, 1'b0, '0},
      '{OP_CHAR,   8'h62, 1'b0, '0},
      '{OP_EOL,    8'h00, 1'b0, '0},
      '{OP_CHAR,   CHAR_SLASH, 1'b0, '0},
      '{OP_EOL,    8'h00, 1'b0, '0},
      '{OP_CHAR,   CHAR_STAR, 1'b0, '0},
      '{OP_CHAR,   CHAR_SLASH, 1'b0, '0},
      '{OP_EOF,    8'h00, 1'b0, '0},
      '{OP_EOF,    8'hFF, 1'b1, '{KIND_FILE, CLASS_BLANK, 24'd0, 24'd0, 24'd0, 24'd0, 32'd0}}
    };

    // hold reset, then release it at a falling edge
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].op, dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].want);
    end

    // random source files: mostly well formed lines, some noise and broken files
    while (items_sent < DIR_ROWS + RANDOM_ITEMS) begin
      nlines = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      repeat (nlines) begin
        len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
        repeat (len) begin
          case ($urandom_range(0, 49))
            0: send_item(OP_UNUSED, 8'($urandom_range(0, 255)));
            1: send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            default: ;
          endcase
          send_item(OP_CHAR, pick_char());
        end
        send_item(OP_EOL, 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 9) < 3) begin
        repeat ($urandom_range(1, 6)) send_item(OP_CHAR, pick_char());
      end
      send_item(OP_EOF, 8'($urandom_range(0, 255)));
    end

    @(negedge clk);
    item_valid <= 1'b0;

    // drain, then a short quiet tail to catch stray results
    while (expected_tallies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items (directed and random files), %0d results, %0d file summaries",
             items_sent, results_seen, files_seen);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
